// ===== rtl/urb_pkg.sv =====
package urb_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int BYTE_W = 8;

	localparam logic [1:0] OP_RX_BYTE = 2'd0;
	localparam logic [1:0] OP_TX_DONE = 2'd1;
	localparam logic [1:0] OP_HOST_READ = 2'd2;
	localparam logic [1:0] OP_HOST_WRITE = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [BYTE_W-1:0] data_byte;
	} urb_in_t;

	typedef struct packed {
		logic read_ok;
		logic [BYTE_W-1:0] read_byte;
		logic send_now;
		logic [BYTE_W-1:0] send_byte;
		logic write_taken;
		logic rx_dropped;
	} urb_out_t;

	typedef struct packed {
		logic push;
		logic pop;
	} urb_ctl_t;

endpackage

// ===== rtl/uart_rx_tx_ring_buffers_unit.sv =====
// result: registered, valid in the cycle after the item transfer
// throughput: one item per cycle while the result is not stalled; each fifo is a chain of byte cells that shifts
// toward the head on a pop, so every event is a single shift or load
// reset: both fifos empty, transmitter idle, no result pending; no clearing pass
module uart_rx_tx_ring_buffers_unit import urb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input urb_in_t item,
	output logic result_valid,
	input logic result_stall,
	output urb_out_t result
);

	urb_ctl_t rx_ctl;
	urb_ctl_t tx_ctl;
	logic [BYTE_W-1:0] rx_head;
	logic [BYTE_W-1:0] tx_head;
	logic rx_empty;
	logic rx_full;
	logic tx_empty;
	logic tx_full;
	logic tx_busy_q;
	logic tx_busy_d;
	logic take;
	logic result_valid_q;
	urb_out_t result_q;
	urb_out_t res;

	assign item_stall = result_valid_q && result_stall;
	assign take = item_valid && !item_stall;

	always_comb begin
		res = '0;
		rx_ctl = '0;
		tx_ctl = '0;
		tx_busy_d = tx_busy_q;
		unique case (item.operation)
			OP_RX_BYTE: begin
				rx_ctl.push = take && !rx_full;
				res.rx_dropped = rx_full;
			end
			OP_TX_DONE: begin
				tx_ctl.pop = take && !tx_empty;
				res.send_now = !tx_empty;
				res.send_byte = tx_empty ? '0 : tx_head;
				tx_busy_d = !tx_empty;
			end
			OP_HOST_READ: begin
				rx_ctl.pop = take && !rx_empty;
				res.read_ok = !rx_empty;
				res.read_byte = rx_empty ? '0 : rx_head;
			end
			OP_HOST_WRITE: begin
				if (!tx_full) begin
					res.write_taken = 1'b1;
					if (!tx_busy_q) begin
						// idle transmitter takes the byte directly
						res.send_now = 1'b1;
						res.send_byte = item.data_byte;
						tx_busy_d = 1'b1;
					end else begin
						tx_ctl.push = take;
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	urb_fifo u_rx_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(rx_ctl),
		.din(item.data_byte),
		.head_data(rx_head),
		.empty(rx_empty),
		.full(rx_full)
	);

	urb_fifo u_tx_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(tx_ctl),
		.din(item.data_byte),
		.head_data(tx_head),
		.empty(tx_empty),
		.full(tx_full)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_busy_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (take) begin
				tx_busy_q <= tx_busy_d;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule

// ===== rtl/urb_cell.sv =====
module urb_cell import urb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input urb_ctl_t ctl,
	input logic prev_valid,
	input logic next_valid,
	input logic [BYTE_W-1:0] next_data,
	input logic [BYTE_W-1:0] din,
	output logic valid,
	output logic [BYTE_W-1:0] data
);

	logic valid_q;
	logic [BYTE_W-1:0] data_q;
	logic load_in;

	// the first empty cell behind a full one takes the pushed byte
	assign load_in = ctl.push && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= next_valid;
		end else if (load_in) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			data_q <= next_data;
		end else if (load_in) begin
			data_q <= din;
		end
	end

	assign valid = valid_q;
	assign data = data_q;

endmodule

// ===== rtl/urb_fifo.sv =====
module urb_fifo import urb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input urb_ctl_t ctl,
	input logic [BYTE_W-1:0] din,
	output logic [BYTE_W-1:0] head_data,
	output logic empty,
	output logic full
);

	// one extra slot past the tail end reads as an empty neighbor
	logic v [FIFO_DEPTH+1];
	logic [BYTE_W-1:0] d [FIFO_DEPTH+1];

	assign v[FIFO_DEPTH] = 1'b0;
	assign d[FIFO_DEPTH] = '0;

	for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
		logic prev_v;
		if (i == 0) begin : g_first
			assign prev_v = 1'b1;
		end else begin : g_rest
			assign prev_v = v[i-1];
		end
		urb_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.prev_valid(prev_v),
			.next_valid(v[i+1]),
			.next_data(d[i+1]),
			.din(din),
			.valid(v[i]),
			.data(d[i])
		);
	end

	assign head_data = d[0];
	assign empty = !v[0];
	assign full = v[FIFO_DEPTH-1];

endmodule

// ===== dv/tb_uart_rx_tx_ring_buffers_unit.sv =====
`timescale 1ns / 1ps

module tb_uart_rx_tx_ring_buffers_unit;
	import urb_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH) + 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int EVENTS_PER_PHASE = 430;
	localparam int MAX_PRINTED = 200;

	typedef struct {
		urb_in_t payload;
		int unsigned send_idle_pct;
		int unsigned recv_stall_pct;
		bit drain_first;
	} pending_ev_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	urb_in_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	urb_out_t result;

	pending_ev_t pending_events[$];
	urb_out_t expected_results[$];
	int unsigned cur_recv_stall = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	// shadow copy of both ring buffers and the transmitter flag
	logic [BYTE_W-1:0] rx_mem [FIFO_DEPTH];
	logic [BYTE_W-1:0] tx_mem [FIFO_DEPTH];
	logic [PTR_W-1:0] rx_rd_ptr = '0;
	logic [PTR_W-1:0] rx_wr_ptr = '0;
	logic [PTR_W-1:0] tx_rd_ptr = '0;
	logic [PTR_W-1:0] tx_wr_ptr = '0;
	logic tx_active = 1'b0;

	logic [1:0] favored_ops [4] = '{OP_RX_BYTE, OP_TX_DONE, OP_HOST_READ, OP_HOST_WRITE};

	uart_rx_tx_ring_buffers_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic urb_out_t predict_uart_event(urb_in_t ev);
		urb_out_t r;
		logic [PTR_W-1:0] rx_fill;
		logic [PTR_W-1:0] tx_fill;
		r = '0;
		rx_fill = rx_wr_ptr - rx_rd_ptr;
		tx_fill = tx_wr_ptr - tx_rd_ptr;
		case (ev.operation)
			OP_RX_BYTE: begin
				if (rx_fill < FIFO_DEPTH) begin
					rx_mem[rx_wr_ptr[PTR_W-2:0]] = ev.data_byte;
					rx_wr_ptr = rx_wr_ptr + 1'b1;
				end else begin
					r.rx_dropped = 1'b1;
				end
			end
			OP_TX_DONE: begin
				if (tx_fill != 0) begin
					r.send_now = 1'b1;
					r.send_byte = tx_mem[tx_rd_ptr[PTR_W-2:0]];
					tx_rd_ptr = tx_rd_ptr + 1'b1;
					tx_active = 1'b1;
				end else begin
					tx_active = 1'b0;
				end
			end
			OP_HOST_READ: begin
				if (rx_fill != 0) begin
					r.read_ok = 1'b1;
					r.read_byte = rx_mem[rx_rd_ptr[PTR_W-2:0]];
					rx_rd_ptr = rx_rd_ptr + 1'b1;
				end
			end
			default: begin
				// a full queue refuses the write outright
				if (tx_fill >= FIFO_DEPTH) begin
					r.write_taken = 1'b0;
				end else if (!tx_active) begin
					r.write_taken = 1'b1;
					r.send_now = 1'b1;
					r.send_byte = ev.data_byte;
					tx_active = 1'b1;
				end else begin
					r.write_taken = 1'b1;
					tx_mem[tx_wr_ptr[PTR_W-2:0]] = ev.data_byte;
					tx_wr_ptr = tx_wr_ptr + 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic void push_event(logic [1:0] op, logic [BYTE_W-1:0] data,
			int unsigned idle_pct, int unsigned stall_pct, bit drain);
		pending_ev_t ev;
		ev.payload.operation = op;
		ev.payload.data_byte = data;
		ev.send_idle_pct = idle_pct;
		ev.recv_stall_pct = stall_pct;
		ev.drain_first = drain;
		pending_events.push_back(ev);
	endfunction

	// bursts, most biased toward one event kind, so both fifos reach full and empty
	task automatic add_random_phase(int unsigned idle_pct, int unsigned stall_pct);
		int unsigned left;
		int unsigned run;
		logic [2:0] bias;
		logic [1:0] op;
		bit first;
		left = EVENTS_PER_PHASE;
		first = 1'b1;
		while (left > 0) begin
			run = $urandom_range(40, 8);
			bias = 3'($urandom_range(4));
			for (int i = 0; i < run && left > 0; i++) begin
				if (bias < 4 && $urandom_range(99) < 80)
					op = favored_ops[bias[1:0]];
				else
					op = 2'($urandom_range(3));
				push_event(op, BYTE_W'($urandom_range(255)), idle_pct, stall_pct, first);
				first = 1'b0;
				left--;
			end
		end
	endtask

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_PRINTED)
			$display("mismatch: %s", msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// driver: one event per transfer, held while stalled
	always @(posedge clk or negedge arst_n) begin
		pending_ev_t ev;
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
		end else begin
			if (item_valid && !item_stall)
				expected_results.push_back(predict_uart_event(item));
			if (!item_valid || !item_stall) begin
				if (pending_events.size() > 0 &&
						!(pending_events[0].drain_first && expected_results.size() > 0) &&
						$urandom_range(99) >= pending_events[0].send_idle_pct) begin
					ev = pending_events.pop_front();
					item_valid <= 1'b1;
					item <= ev.payload;
					cur_recv_stall <= ev.recv_stall_pct;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transfer with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		urb_out_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no pending event");
				end else begin
					want = expected_results.pop_front();
					check_field("read_ok", BYTE_W'(result.read_ok), BYTE_W'(want.read_ok));
					check_field("read_byte", result.read_byte, want.read_byte);
					check_field("send_now", BYTE_W'(result.send_now), BYTE_W'(want.send_now));
					check_field("send_byte", result.send_byte, want.send_byte);
					check_field("write_taken", BYTE_W'(result.write_taken),
						BYTE_W'(want.write_taken));
					check_field("rx_dropped", BYTE_W'(result.rx_dropped),
						BYTE_W'(want.rx_dropped));
				end
			end
			result_stall <= ($urandom_range(99) < cur_recv_stall);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		// empty reads, idle transmit done, immediate and queued writes, received bytes read back
		push_event(OP_HOST_READ, 8'h00, 0, 0, 1'b0);
		push_event(OP_TX_DONE, 8'hff, 0, 0, 1'b0);
		push_event(OP_HOST_WRITE, 8'h00, 0, 0, 1'b0);
		push_event(OP_HOST_WRITE, 8'hff, 0, 0, 1'b0);
		push_event(OP_HOST_WRITE, 8'h5a, 0, 0, 1'b0);
		push_event(OP_TX_DONE, 8'h00, 0, 0, 1'b0);
		push_event(OP_TX_DONE, 8'h00, 0, 0, 1'b0);
		push_event(OP_TX_DONE, 8'h00, 0, 0, 1'b0);
		push_event(OP_TX_DONE, 8'h00, 0, 0, 1'b0);
		push_event(OP_RX_BYTE, 8'h00, 0, 0, 1'b0);
		push_event(OP_RX_BYTE, 8'hff, 0, 0, 1'b0);
		push_event(OP_RX_BYTE, 8'ha5, 0, 0, 1'b0);
		push_event(OP_HOST_READ, 8'hff, 0, 0, 1'b0);
		push_event(OP_HOST_READ, 8'h00, 0, 0, 1'b0);
		push_event(OP_HOST_READ, 8'h00, 0, 0, 1'b0);
		push_event(OP_HOST_READ, 8'h00, 0, 0, 1'b0);
		push_event(OP_HOST_WRITE, 8'h81, 0, 0, 1'b0);
		push_event(OP_HOST_WRITE, 8'h7e, 0, 0, 1'b0);
		push_event(OP_TX_DONE, 8'h00, 0, 0, 1'b0);
		push_event(OP_TX_DONE, 8'h00, 0, 0, 1'b0);

		add_random_phase(0, 0);
		add_random_phase(85, 0);
		add_random_phase(0, 85);
		add_random_phase(12, 12);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() > 0 || item_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
